// File: rtl/core/mred_pkg.sv
package mred_pkg;
    localparam int NUM_CH           = 3;
    localparam int MAX_HANDLERS_DEF = 8;
    localparam int TICK_WRAP_DEF    = 10000;
    localparam int PERIOD_W         = 16;
    localparam int TICK_W           = 14;
    localparam int ID_W             = 8;
    localparam int CNT_W            = 5;

    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_REG    = 2'd1;
    localparam logic [1:0] REQ_UNREG  = 2'd2;

    localparam logic [1:0] KIND_CALL  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_REG   = 2'd2;
    localparam logic [1:0] KIND_UNREG = 2'd3;

    localparam logic [1:0] CFG_FAST = 2'd0;
    localparam logic [1:0] CFG_MID  = 2'd1;
    localparam logic [1:0] CFG_SLOW = 2'd2;

    localparam logic [PERIOD_W-1:0] PERIOD_FAST_RST = 16'd625;
    localparam logic [PERIOD_W-1:0] PERIOD_MID_RST  = 16'd6250;
    localparam logic [PERIOD_W-1:0] PERIOD_SLOW_RST = 16'd62500;

    // controller -> datapath
    typedef struct packed {
        logic       load;      // capture input word
        logic       chk;       // evaluate channel ch: fire test, stamp, tick
        logic       emit_call; // present call for ch at index idx
        logic       emit_done;
        logic       reg_op;    // perform register and present status
        logic       unreg_chk; // compare entry idx; swap on match
        logic       emit_unreg;
        logic [1:0] ch;
    } mred_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] req;
        logic       out_busy;  // output register holds a word not yet taken
        logic       fired;     // channel under test fired (after chk)
        logic       idx_end;   // idx reached count
    } mred_sts_t;
endpackage

// File: rtl/core/mred_ram.sv
module mred_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 24
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/core/mred_ctrl.sv
module mred_ctrl
    import mred_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  mred_sts_t sts,
    output mred_cmd_t cmd
);
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DEC    = 4'd1;
    localparam logic [3:0] ST_CHK    = 4'd2;
    localparam logic [3:0] ST_RD     = 4'd3;
    localparam logic [3:0] ST_CALL   = 4'd4;
    localparam logic [3:0] ST_DONE   = 4'd5;
    localparam logic [3:0] ST_REG    = 4'd6;
    localparam logic [3:0] ST_URD    = 4'd7;
    localparam logic [3:0] ST_UCHK   = 4'd8;
    localparam logic [3:0] ST_UOUT   = 4'd9;
    localparam logic [3:0] ST_TEST   = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [1:0] ch_reg, ch_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ch_reg    <= 2'd0;
        end else begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ch_next    = ch_reg;
        cmd        = '0;
        cmd.ch     = ch_reg;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_DEC;
                    ch_next    = 2'd0;
                end
            end
            ST_DEC: begin
                case (sts.req)
                    REQ_SAMPLE: state_next = ST_CHK;
                    REQ_REG:    state_next = ST_REG;
                    REQ_UNREG:  state_next = ST_URD;
                    default:    state_next = ST_IDLE;
                endcase
            end
            ST_CHK: begin
                cmd.chk    = 1'b1;
                state_next = ST_TEST;
            end
            ST_TEST: begin
                if (sts.fired) begin
                    state_next = ST_RD;
                end else if (ch_reg == 2'd2) begin
                    state_next = ST_DONE;
                end else begin
                    ch_next    = ch_reg + 2'd1;
                    state_next = ST_CHK;
                end
            end
            ST_RD: begin
                // table read of entry idx is issued; data valid next cycle
                if (sts.idx_end) begin
                    if (ch_reg == 2'd2) begin
                        state_next = ST_DONE;
                    end else begin
                        ch_next    = ch_reg + 2'd1;
                        state_next = ST_CHK;
                    end
                end else begin
                    state_next = ST_CALL;
                end
            end
            ST_CALL: begin
                if (!sts.out_busy) begin
                    cmd.emit_call = 1'b1;
                    state_next    = ST_RD;
                end
            end
            ST_DONE: begin
                if (!sts.out_busy) begin
                    cmd.emit_done = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_REG: begin
                if (!sts.out_busy) begin
                    cmd.reg_op = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_URD: begin
                state_next = sts.idx_end ? ST_UOUT : ST_UCHK;
            end
            ST_UCHK: begin
                cmd.unreg_chk = 1'b1;
                state_next    = ST_URD;
            end
            ST_UOUT: begin
                if (!sts.out_busy) begin
                    cmd.emit_unreg = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

// File: rtl/core/mred_dp.sv
module mred_dp
    import mred_pkg::*;
#(
    parameter int MAX_HANDLERS = MAX_HANDLERS_DEF,
    parameter int TICK_WRAP    = TICK_WRAP_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  mred_cmd_t           cmd,
    output mred_sts_t           sts,
    input  logic [1:0]          s_tuser,
    input  logic [25:0]         s_tdata,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [PERIOD_W-1:0] cfg_data,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [1:0]          m_tuser,
    output logic [39:0]         m_tdata,
    output logic                m_tlast
);
    localparam int IDX_W = $clog2(MAX_HANDLERS + 1);
    localparam int DEPTH = NUM_CH * MAX_HANDLERS;
    localparam int AW    = $clog2(DEPTH);

    logic [PERIOD_W-1:0] period_reg [NUM_CH];
    logic [PERIOD_W-1:0] stamp_reg  [NUM_CH];
    logic [TICK_W-1:0]   tick_reg   [NUM_CH];
    logic [CNT_W-1:0]    count_reg  [NUM_CH];

    logic [1:0]          req_reg, sel_reg;
    logic [ID_W-1:0]     id_reg;
    logic [PERIOD_W-1:0] now_reg;
    logic [2:0]          mask_reg;
    logic                fired_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [CNT_W-1:0]    found_reg;

    logic                ovalid_reg;
    logic [1:0]          okind_reg;
    logic [39:0]         odata_reg;
    logic                olast_reg;

    logic [1:0]          ch;
    logic [PERIOD_W-1:0] elapsed;
    logic [CNT_W-1:0]    cnt_ch, cnt_sel;
    logic [ID_W-1:0]     rdata;
    logic                we;
    logic [AW-1:0]       waddr, raddr;
    logic [ID_W-1:0]     wdata;
    logic [TICK_W-1:0]   tick_inc;
    logic                sel_ok;
    logic                swap;
    logic [ID_W-1:0]     last_rdata;
    logic [AW-1:0]       laddr;

    assign ch      = cmd.ch;
    assign elapsed = now_reg - stamp_reg[ch];
    assign cnt_ch  = count_reg[ch];
    assign sel_ok  = (sel_reg != 2'd3);
    assign cnt_sel = sel_ok ? count_reg[sel_reg] : '0;

    function automatic logic [AW-1:0] addr_of(logic [1:0] c, logic [IDX_W-1:0] i);
        logic [AW+IDX_W:0] a;
        a = AW'(c) * (AW+IDX_W+1)'(MAX_HANDLERS) + (AW+IDX_W+1)'(i);
        return a[AW-1:0];
    endfunction

    // read address: sample walk uses ch/idx, unregister uses sel/idx
    always_comb begin
        if (req_reg == REQ_UNREG && sel_ok) begin
            raddr = addr_of(sel_reg, idx_reg);
        end else begin
            raddr = addr_of(ch, idx_reg);
        end
    end

    // writes: register append, or unregister swap-in of the last entry
    assign swap = cmd.unreg_chk && (rdata == id_reg);

    always_comb begin
        we    = 1'b0;
        waddr = addr_of(sel_ok ? sel_reg : 2'd0, idx_reg);
        wdata = id_reg;
        if (cmd.reg_op && sel_ok && cnt_sel < CNT_W'(MAX_HANDLERS)) begin
            we    = 1'b1;
            waddr = addr_of(sel_reg, IDX_W'(cnt_sel));
        end else if (swap) begin
            we    = 1'b1;
            wdata = last_rdata;
        end
    end

    // the table is kept in a second copy, from which the last entry is read alongside
    assign laddr = addr_of(sel_ok ? sel_reg : 2'd0, IDX_W'(cnt_sel - CNT_W'(1)));

    mred_ram #(.WIDTH(ID_W), .DEPTH(DEPTH)) u_tab (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );
    mred_ram #(.WIDTH(ID_W), .DEPTH(DEPTH)) u_tab_last (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(laddr), .rdata(last_rdata)
    );

    assign tick_inc = (tick_reg[ch] == TICK_W'(TICK_WRAP - 1)) ? '0 : tick_reg[ch] + 1'b1;

    assign sts.req      = req_reg;
    assign sts.out_busy = ovalid_reg && !m_tready;
    assign sts.fired    = fired_reg;
    assign sts.idx_end  = (req_reg == REQ_UNREG) ?
                          (!sel_ok || CNT_W'(idx_reg) >= cnt_sel) :
                          (CNT_W'(idx_reg) >= cnt_ch);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg[0] <= PERIOD_FAST_RST;
            period_reg[1] <= PERIOD_MID_RST;
            period_reg[2] <= PERIOD_SLOW_RST;
            for (int c = 0; c < NUM_CH; c++) begin
                stamp_reg[c] <= '0;
                tick_reg[c]  <= '0;
                count_reg[c] <= '0;
            end
            ovalid_reg <= 1'b0;
            fired_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_FAST: period_reg[0] <= cfg_data;
                    CFG_MID:  period_reg[1] <= cfg_data;
                    CFG_SLOW: period_reg[2] <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.chk) begin
                fired_reg <= elapsed > period_reg[ch];
                if (elapsed > period_reg[ch]) begin
                    stamp_reg[ch] <= now_reg;
                    tick_reg[ch]  <= tick_inc;
                end
            end
            if (cmd.reg_op && sel_ok && cnt_sel < CNT_W'(MAX_HANDLERS)) begin
                count_reg[sel_reg] <= cnt_sel + 1'b1;
            end
            if (swap) begin
                count_reg[sel_reg] <= cnt_sel - 1'b1;
            end
            if (cmd.emit_call || cmd.emit_done || cmd.reg_op || cmd.emit_unreg) begin
                ovalid_reg <= 1'b1;
            end else if (ovalid_reg && m_tready) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // payload: channel, call_id, tick, mask, accepted, removed, pad; kind on tuser
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg   <= s_tuser;
            sel_reg   <= s_tdata[1:0];
            id_reg    <= s_tdata[9:2];
            now_reg   <= s_tdata[25:10];
            mask_reg  <= '0;
            idx_reg   <= '0;
            found_reg <= '0;
        end
        if (cmd.chk) begin
            idx_reg <= '0;
            if (elapsed > period_reg[ch]) begin
                mask_reg[ch] <= 1'b1;
            end
        end
        if (cmd.emit_call) begin
            idx_reg   <= idx_reg + 1'b1;
            okind_reg <= KIND_CALL;
            odata_reg <= {7'd0, 5'd0, 1'b0, 3'd0, tick_reg[ch], rdata, ch};
            olast_reg <= 1'b0;
        end
        if (cmd.unreg_chk) begin
            if (swap) begin
                found_reg <= found_reg + 1'b1;
            end else begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
        if (cmd.emit_done) begin
            okind_reg <= KIND_DONE;
            odata_reg <= {7'd0, 5'd0, 1'b0, mask_reg, 14'd0, 8'd0, 2'd0};
            olast_reg <= 1'b1;
        end
        if (cmd.reg_op) begin
            okind_reg <= KIND_REG;
            odata_reg <= {7'd0, 5'd0, sel_ok && cnt_sel < CNT_W'(MAX_HANDLERS),
                          3'd0, 14'd0, 8'd0, sel_reg};
            olast_reg <= 1'b1;
        end
        if (cmd.emit_unreg) begin
            okind_reg <= KIND_UNREG;
            odata_reg <= {7'd0, found_reg, 1'b0, 3'd0, 14'd0, 8'd0, sel_reg};
            olast_reg <= 1'b1;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tuser  = okind_reg;
    assign m_tdata  = odata_reg;
    assign m_tlast  = olast_reg;
endmodule

// File: rtl/core/multi_rate_event_dispatcher.sv
// Three-channel periodic event dispatcher. Each input word is a time sample,
// a handler registration or an unregistration, told apart by tuser. A time
// sample tests the fast, middle and slow channels in turn; a channel whose
// elapsed time (mod 2^16) exceeds its period takes the new stamp, advances its
// tick (wrapping at TICK_WRAP) and emits one call word per subscriber in table
// order, then a sample-done word with tlast ends the run. Registration and
// unregistration answer with one status word. Items are handled one at a time.
// After the accepting cycle a sample passes decode, a test and a decision state
// per channel and the done word; a firing channel adds a read and a call state
// per call word, set by the registered table read, and a final read. A register
// passes decode and the register state; an unregister passes decode, a read and
// a compare state per visited entry (a slot refilled by a swap counting again),
// a final read and the status state. The output register decouples the result
// side; call, done and status states stall while it holds an untaken word. The
// user must write periods on the cfg port while the block is idle (unchecked).
module multi_rate_event_dispatcher
    import mred_pkg::*;
#(
    parameter int MAX_HANDLERS = MAX_HANDLERS_DEF,
    parameter int TICK_WRAP    = TICK_WRAP_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // req_type[1:0]
    input  logic [1:0]          s_tuser,
    // rate_sel[1:0], handler_id[9:2], timer_value[25:10], pad
    input  logic [31:0]         s_tdata,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [PERIOD_W-1:0] cfg_data,
    output logic                m_tvalid,
    input  logic                m_tready,
    // result_kind[1:0]
    output logic [1:0]          m_tuser,
    // channel[1:0], call_id[9:2], tick_value[23:10], fired_mask[26:24],
    // accepted[27], removed_count[32:28], pad
    output logic [39:0]         m_tdata,
    output logic                m_tlast
);
    mred_cmd_t cmd;
    mred_sts_t sts;

    mred_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .sts(sts), .cmd(cmd)
    );

    mred_dp #(.MAX_HANDLERS(MAX_HANDLERS), .TICK_WRAP(TICK_WRAP)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .s_tuser(s_tuser), .s_tdata(s_tdata[25:0]),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tuser(m_tuser), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );
endmodule
